/* rtl/tplv_pkg.sv */
// Shared constants and types for the two-point-light vertex shader.
`timescale 1ns / 1ps
package tplv_pkg;
	localparam int FIELD_W = 16;
	localparam int FRAC_BITS = 12;
	localparam int CFG_W = 48;
	localparam int NUM_LIGHTS = 2;
	localparam int DIR_W = 17;
	localparam int D_W = 22;
	localparam int LD_NW = 28;
	localparam int LD_W = 29;
	localparam int ATT_W = 32;
	localparam int ATT_NW = 43;
	localparam int SQ_IW = 44;
	localparam int SQ_RW = 22;
	localparam int ROUND_ADD = 64;
	localparam int ROUND_SHIFT = 7;
	localparam int CHAN_MAX = 31;
	localparam int CHAN_W = 5;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_W-1:0] L1_POS_RST = 48'hF000_0C64_F000;
	localparam logic [CFG_W-1:0] L1_COL_RST = 48'h2000_2000_2000;
	localparam logic [CFG_W-1:0] L2_POS_RST = 48'h1000_1000_1000;
	localparam logic [CFG_W-1:0] L2_COL_RST = 48'h0000_0000_2000;

	typedef enum logic [1:0] {
		REG_L1_POS = 2'd0,
		REG_L1_COL = 2'd1,
		REG_L2_POS = 2'd2,
		REG_L2_COL = 2'd3
	} reg_idx_t;

	// one vertex after the front: light vectors, normal, squared lengths
	typedef struct packed {
		logic [NUM_LIGHTS-1:0][2:0][DIR_W-1:0] dir;
		logic [2:0][FIELD_W-1:0] nrm;
		logic [NUM_LIGHTS-1:0][D_W-1:0] d;
	} qent_t;
endpackage

/* rtl/tplv_front.sv */
// Front: accepts vertices, forms light vectors and squared lengths.
`timescale 1ns / 1ps
module tplv_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [tplv_pkg::FIELD_W-1:0] vertex_x,
	input  logic signed [tplv_pkg::FIELD_W-1:0] vertex_y,
	input  logic signed [tplv_pkg::FIELD_W-1:0] vertex_z,
	input  logic signed [tplv_pkg::FIELD_W-1:0] normal_x,
	input  logic signed [tplv_pkg::FIELD_W-1:0] normal_y,
	input  logic signed [tplv_pkg::FIELD_W-1:0] normal_z,
	input  logic [tplv_pkg::CFG_W-1:0] light_one_position,
	input  logic [tplv_pkg::CFG_W-1:0] light_two_position,
	input  logic queue_full,
	output logic push,
	output tplv_pkg::qent_t entry
);
	localparam int FW = tplv_pkg::FIELD_W;
	localparam int DW = tplv_pkg::DIR_W;
	localparam int NL = tplv_pkg::NUM_LIGHTS;

	logic valid_s1;
	logic [NL-1:0][2:0][DW-1:0] dir_s1;
	logic [2:0][FW-1:0] nrm_s1;
	logic [NL-1:0][2:0][DW-1:0] dir_n;
	logic advance;

	assign advance = !valid_s1 || !queue_full;
	assign in_ready = advance;
	assign push = valid_s1 && !queue_full;

	always_comb begin
		logic [2:0][FW-1:0] vtx;
		logic [FW-1:0] lp;
		vtx = {vertex_z, vertex_y, vertex_x};
		for (int l = 0; l < NL; l++) begin
			for (int k = 0; k < 3; k++) begin
				lp = (l == 0) ? light_one_position[FW*k +: FW] : light_two_position[FW*k +: FW];
				dir_n[l][k] = {lp[FW-1], lp} - {vtx[k][FW-1], vtx[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			dir_s1 <= dir_n;
			nrm_s1 <= {normal_z, normal_y, normal_x};
		end
	end

	// squared length; each square is nonnegative so the floor is a plain shift
	always_comb begin
		logic signed [DW-1:0] ds;
		logic signed [2*DW-1:0] sq;
		logic [tplv_pkg::D_W-1:0] acc;
		entry.dir = dir_s1;
		entry.nrm = nrm_s1;
		for (int l = 0; l < NL; l++) begin
			acc = '0;
			for (int k = 0; k < 3; k++) begin
				ds = $signed(dir_s1[l][k]);
				sq = (2*DW)'(ds) * (2*DW)'(ds);
				acc = acc + tplv_pkg::D_W'(sq[31:tplv_pkg::FRAC_BITS]);
			end
			entry.d[l] = acc;
		end
	end
endmodule

/* rtl/tplv_queue.sv */
// Short FIFO between front and back.
`timescale 1ns / 1ps
module tplv_queue #(
	parameter int DEPTH = tplv_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tplv_pkg::qent_t wdata,
	output logic full,
	input  logic pop,
	output tplv_pkg::qent_t rdata,
	output logic empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tplv_pkg::qent_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end
endmodule

/* rtl/tplv_div.sv */
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`timescale 1ns / 1ps
module tplv_div #(
	parameter int LANES = 1,
	parameter int NW = tplv_pkg::LD_NW,
	parameter int DW = tplv_pkg::D_W,
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [LANES-1:0][NW-1:0] num,
	input  logic [LANES-1:0][DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic out_valid,
	output logic [LANES-1:0][NW-1:0] quo,
	output logic [SW-1:0] out_side
);
	logic [NW-1:0] valid_q;
	logic [LANES-1:0][NW-1:0] nq_q [NW];
	logic [LANES-1:0][DW-1:0] rem_q [NW];
	logic [LANES-1:0][DW-1:0] den_q [NW];
	logic [SW-1:0] side_q [NW];

	logic [LANES-1:0][NW-1:0] nq_c [NW];
	logic [LANES-1:0][DW-1:0] rem_c [NW];
	logic [LANES-1:0][DW-1:0] den_c [NW];
	logic [SW-1:0] side_c [NW];
	logic [LANES-1:0][NW-1:0] nq_n [NW];
	logic [LANES-1:0][DW-1:0] rem_n [NW];

	// stage inputs: the first stage takes the ports
	always_comb begin
		nq_c[0] = num;
		rem_c[0] = '0;
		den_c[0] = den;
		side_c[0] = side;
		for (int j = 1; j < NW; j++) begin
			nq_c[j] = nq_q[j-1];
			rem_c[j] = rem_q[j-1];
			den_c[j] = den_q[j-1];
			side_c[j] = side_q[j-1];
		end
	end

	always_comb begin
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic ge;
		for (int j = 0; j < NW; j++) begin
			for (int l = 0; l < LANES; l++) begin
				trial = {rem_c[j][l], nq_c[j][l][NW-1]};
				diff = trial - {1'b0, den_c[j][l]};
				ge = (trial >= {1'b0, den_c[j][l]});
				rem_n[j][l] = ge ? diff[DW-1:0] : trial[DW-1:0];
				nq_n[j][l] = {nq_c[j][l][NW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[NW-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NW; j++) begin
				nq_q[j] <= nq_n[j];
				rem_q[j] <= rem_n[j];
				den_q[j] <= den_c[j];
				side_q[j] <= side_c[j];
			end
		end
	end

	assign out_valid = valid_q[NW-1];
	assign quo = nq_q[NW-1];
	assign out_side = side_q[NW-1];
endmodule

/* rtl/tplv_sqrt.sv */
// Pipelined integer square root, one root bit per stage, several lanes.
`timescale 1ns / 1ps
module tplv_sqrt #(
	parameter int LANES = 3,
	parameter int IW = tplv_pkg::SQ_IW
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [LANES-1:0][IW-1:0] val,
	output logic out_valid,
	output logic [LANES-1:0][IW/2-1:0] root
);
	localparam int HW = IW / 2;
	localparam int RW = HW + 3;

	logic [HW-1:0] valid_q;
	logic [LANES-1:0][IW-1:0] val_q [HW];
	logic [LANES-1:0][RW-1:0] rem_q [HW];
	logic [LANES-1:0][HW-1:0] root_q [HW];

	logic [LANES-1:0][IW-1:0] val_c [HW];
	logic [LANES-1:0][RW-1:0] rem_c [HW];
	logic [LANES-1:0][HW-1:0] root_c [HW];
	logic [LANES-1:0][IW-1:0] val_n [HW];
	logic [LANES-1:0][RW-1:0] rem_n [HW];
	logic [LANES-1:0][HW-1:0] root_n [HW];

	always_comb begin
		val_c[0] = val;
		rem_c[0] = '0;
		root_c[0] = '0;
		for (int j = 1; j < HW; j++) begin
			val_c[j] = val_q[j-1];
			rem_c[j] = rem_q[j-1];
			root_c[j] = root_q[j-1];
		end
	end

	// bring down the next bit pair, try (root << 2) | 1
	always_comb begin
		logic [RW-1:0] cand;
		logic [RW-1:0] trial;
		logic ge;
		for (int j = 0; j < HW; j++) begin
			for (int l = 0; l < LANES; l++) begin
				cand = {rem_c[j][l][RW-3:0], val_c[j][l][IW-1:IW-2]};
				trial = RW'({root_c[j][l], 2'b01});
				ge = (cand >= trial);
				rem_n[j][l] = ge ? cand - trial : cand;
				root_n[j][l] = {root_c[j][l][HW-2:0], ge};
				val_n[j][l] = {val_c[j][l][IW-3:0], 2'b00};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[HW-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < HW; j++) begin
				val_q[j] <= val_n[j];
				rem_q[j] <= rem_n[j];
				root_q[j] <= root_n[j];
			end
		end
	end

	assign out_valid = valid_q[HW-1];
	assign root = root_q[HW-1];
endmodule

/* rtl/tplv_back.sv */
// Back: per-light divides, diffuse term, attenuation, channel sums, root.
`timescale 1ns / 1ps
module tplv_back (
	input  logic clk,
	input  logic arst_n,
	input  tplv_pkg::qent_t entry,
	input  logic empty,
	output logic pop,
	input  logic [tplv_pkg::CFG_W-1:0] light_one_colour,
	input  logic [tplv_pkg::CFG_W-1:0] light_two_colour,
	output logic out_valid,
	input  logic out_ready,
	output logic [tplv_pkg::CHAN_W-1:0] red,
	output logic [tplv_pkg::CHAN_W-1:0] green,
	output logic [tplv_pkg::CHAN_W-1:0] blue
);
	localparam int NL = tplv_pkg::NUM_LIGHTS;
	localparam int FW = tplv_pkg::FIELD_W;
	localparam int FB = tplv_pkg::FRAC_BITS;
	localparam int DW = tplv_pkg::D_W;
	localparam int LNW = tplv_pkg::LD_NW;
	localparam int LW = tplv_pkg::LD_W;
	localparam int AW = tplv_pkg::ATT_W;
	localparam int ANW = tplv_pkg::ATT_NW;
	localparam int IW = tplv_pkg::SQ_IW;
	localparam int RW = tplv_pkg::SQ_RW;
	localparam int CW = tplv_pkg::CHAN_W;
	localparam int LDSW = 3 * FW + NL * AW + 3 * NL;
	localparam int ATSW = 2 * NL;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	// stage 1: operands for the light-vector divides, attenuation square
	logic [NL*3-1:0][LNW-1:0] num_s1;
	logic [NL*3-1:0][DW-1:0] den_s1;
	logic [NL*3-1:0] neg_s1;
	logic [NL-1:0][AW-1:0] att_s1;
	logic [2:0][FW-1:0] nrm_s1;

	logic ld_valid;
	logic [NL*3-1:0][LNW-1:0] ld_quo;
	logic [LDSW-1:0] ld_side;

	logic [NL-1:0][2:0][AW-1:0] dprod_s2;
	logic [NL-1:0][AW-1:0] att_s2;

	logic [NL-1:0][ANW-1:0] num_s3;
	logic [NL-1:0][AW-1:0] den_s3;
	logic [NL-1:0] skip_s3;
	logic [NL-1:0] aneg_s3;

	logic at_valid;
	logic [NL-1:0][ANW-1:0] at_quo;
	logic [ATSW-1:0] at_side;

	logic [NL-1:0][2:0][AW-1:0] cprod_s4;
	logic [2:0][IW-1:0] sq_s5;

	logic sq_valid;
	logic [2:0][RW-1:0] sq_root;
	logic [2:0][CW-1:0] chan_s6;

	logic [NL*3-1:0][LNW-1:0] num_s1_n;
	logic [NL*3-1:0][DW-1:0] den_s1_n;
	logic [NL*3-1:0] neg_s1_n;
	logic [NL-1:0][AW-1:0] att_s1_n;

	assign out_valid = valid_s6;
	assign en = !valid_s6 || out_ready;
	assign pop = en && !empty;

	always_comb begin
		logic [tplv_pkg::DIR_W-1:0] dv;
		logic [tplv_pkg::DIR_W-1:0] mag;
		logic [2*DW-1:0] dd;
		for (int l = 0; l < NL; l++) begin
			for (int k = 0; k < 3; k++) begin
				dv = entry.dir[l][k];
				mag = dv[tplv_pkg::DIR_W-1] ? -dv : dv;
				num_s1_n[3*l+k] = {mag[FW-1:0], {FB{1'b0}}};
				den_s1_n[3*l+k] = entry.d[l];
				neg_s1_n[3*l+k] = dv[tplv_pkg::DIR_W-1];
			end
			dd = (2*DW)'(entry.d[l]) * (2*DW)'(entry.d[l]);
			att_s1_n[l] = dd[AW+FB-1:FB];
		end
	end

	tplv_div #(
		.LANES(NL * 3),
		.NW(LNW),
		.DW(DW),
		.SW(LDSW)
	) u_ld_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(valid_s1),
		.num(num_s1),
		.den(den_s1),
		.side({nrm_s1, att_s1, neg_s1}),
		.out_valid(ld_valid),
		.quo(ld_quo),
		.out_side(ld_side)
	);

	// stage 2: normal times swapped light direction
	logic [NL-1:0][2:0][AW-1:0] dprod_n;
	always_comb begin
		logic [2:0][FW-1:0] nrm;
		logic [NL*3-1:0] neg;
		logic signed [LW-1:0] ld;
		logic signed [FW+LW-1:0] p;
		int lane;
		nrm = ld_side[LDSW-1 -: 3*FW];
		neg = ld_side[3*NL-1:0];
		for (int l = 0; l < NL; l++) begin
			for (int k = 0; k < 3; k++) begin
				// y and z of the light direction trade places
				lane = 3 * l + ((k == 0) ? 0 : 3 - k);
				ld = neg[lane] ? -$signed({1'b0, ld_quo[lane]}) : $signed({1'b0, ld_quo[lane]});
				p = (FW+LW)'($signed(nrm[k])) * (FW+LW)'(ld);
				dprod_n[l][k] = p[AW+FB-1:FB];
			end
		end
	end

	// stage 3: clamp the diffuse term, set up the attenuation divide
	logic [NL-1:0][ANW-1:0] num_s3_n;
	logic [NL-1:0][AW-1:0] den_s3_n;
	logic [NL-1:0] skip_s3_n;
	logic [NL-1:0] aneg_s3_n;
	always_comb begin
		logic [AW-1:0] acc;
		logic [AW-1:0] a;
		for (int l = 0; l < NL; l++) begin
			acc = dprod_s2[l][0] + dprod_s2[l][1] + dprod_s2[l][2];
			num_s3_n[l] = acc[AW-1] ? '0 : {acc[AW-2:0], {FB{1'b0}}};
			a = att_s2[l];
			den_s3_n[l] = a[AW-1] ? -a : a;
			aneg_s3_n[l] = a[AW-1];
			skip_s3_n[l] = (a == '0);
		end
	end

	tplv_div #(
		.LANES(NL),
		.NW(ANW),
		.DW(AW),
		.SW(ATSW)
	) u_att_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(valid_s3),
		.num(num_s3),
		.den(den_s3),
		.side({skip_s3, aneg_s3}),
		.out_valid(at_valid),
		.quo(at_quo),
		.out_side(at_side)
	);

	// stage 4: scale by light colour
	logic [NL-1:0][2:0][AW-1:0] cprod_n;
	always_comb begin
		logic [AW-1:0] q;
		logic [AW-1:0] inten;
		logic [FW-1:0] col;
		logic signed [FW+AW:0] p;
		for (int l = 0; l < NL; l++) begin
			q = at_quo[l][AW-1:0];
			inten = at_side[l] ? -q : q;
			if (at_side[NL+l]) begin
				inten = '0;
			end
			for (int c = 0; c < 3; c++) begin
				col = (l == 0) ? light_one_colour[FW*c +: FW] : light_two_colour[FW*c +: FW];
				p = (FW+AW+1)'($signed({1'b0, col})) * (FW+AW+1)'($signed(inten));
				cprod_n[l][c] = p[AW+FB-1:FB];
			end
		end
	end

	// stage 5: channel sums, clamp, shift up for the root
	logic [2:0][IW-1:0] sq_n;
	always_comb begin
		logic [AW-1:0] s;
		for (int c = 0; c < 3; c++) begin
			s = cprod_s4[0][c] + cprod_s4[1][c];
			sq_n[c] = s[AW-1] ? '0 : IW'({s[AW-2:0], {FB{1'b0}}});
		end
	end

	tplv_sqrt #(
		.LANES(3),
		.IW(IW)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(valid_s5),
		.val(sq_s5),
		.out_valid(sq_valid),
		.root(sq_root)
	);

	// stage 6: round to 5 bits and saturate
	logic [2:0][CW-1:0] chan_n;
	always_comb begin
		logic [RW:0] t;
		logic [RW-tplv_pkg::ROUND_SHIFT:0] c5;
		for (int c = 0; c < 3; c++) begin
			t = {1'b0, sq_root[c]} + (RW + 1)'(tplv_pkg::ROUND_ADD);
			c5 = t[RW:tplv_pkg::ROUND_SHIFT];
			chan_n[c] = (c5 > (RW - tplv_pkg::ROUND_SHIFT + 1)'(tplv_pkg::CHAN_MAX)) ?
				CW'(tplv_pkg::CHAN_MAX) : c5[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= !empty;
			valid_s2 <= ld_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= at_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= num_s1_n;
			den_s1 <= den_s1_n;
			neg_s1 <= neg_s1_n;
			att_s1 <= att_s1_n;
			nrm_s1 <= entry.nrm;
			dprod_s2 <= dprod_n;
			att_s2 <= ld_side[3*NL + NL*AW - 1 : 3*NL];
			num_s3 <= num_s3_n;
			den_s3 <= den_s3_n;
			skip_s3 <= skip_s3_n;
			aneg_s3 <= aneg_s3_n;
			cprod_s4 <= cprod_n;
			sq_s5 <= sq_n;
			chan_s6 <= chan_n;
		end
	end

	assign red = chan_s6[0];
	assign green = chan_s6[1];
	assign blue = chan_s6[2];
endmodule

/* rtl/two_point_light_vertex_shade.sv */
// Top level of the two-point-light vertex shader.
// Takes one vertex (position and normal, signed 4.12) per beat and returns its
// RGB555 colour lit by two point lights held in four 48-bit registers. The block
// sustains one vertex per clock while the output is not stalled. The back holds the
// 28-stage light vector divider, the 43-stage attenuation divider and the 22-stage
// square root, all pipelined one bit per stage. A small queue between the front
// and the back absorbs output stalls. Write the light registers only while idle.
`timescale 1ns / 1ps
module two_point_light_vertex_shade #(
	parameter int QUEUE_DEPTH = tplv_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [tplv_pkg::CFG_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [tplv_pkg::FIELD_W-1:0] vertex_x,
	input  logic signed [tplv_pkg::FIELD_W-1:0] vertex_y,
	input  logic signed [tplv_pkg::FIELD_W-1:0] vertex_z,
	input  logic signed [tplv_pkg::FIELD_W-1:0] normal_x,
	input  logic signed [tplv_pkg::FIELD_W-1:0] normal_y,
	input  logic signed [tplv_pkg::FIELD_W-1:0] normal_z,
	output logic out_valid,
	input  logic out_ready,
	output logic [tplv_pkg::CHAN_W-1:0] red,
	output logic [tplv_pkg::CHAN_W-1:0] green,
	output logic [tplv_pkg::CHAN_W-1:0] blue
);
	logic [tplv_pkg::CFG_W-1:0] l1_pos_q, l1_col_q, l2_pos_q, l2_col_q;
	logic q_push, q_pop, q_full, q_empty;
	tplv_pkg::qent_t q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_pos_q <= tplv_pkg::L1_POS_RST;
			l1_col_q <= tplv_pkg::L1_COL_RST;
			l2_pos_q <= tplv_pkg::L2_POS_RST;
			l2_col_q <= tplv_pkg::L2_COL_RST;
		end else if (cfg_we) begin
			unique case (tplv_pkg::reg_idx_t'(cfg_index))
				tplv_pkg::REG_L1_POS: l1_pos_q <= cfg_data;
				tplv_pkg::REG_L1_COL: l1_col_q <= cfg_data;
				tplv_pkg::REG_L2_POS: l2_pos_q <= cfg_data;
				tplv_pkg::REG_L2_COL: l2_col_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tplv_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.vertex_z(vertex_z),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.light_one_position(l1_pos_q),
		.light_two_position(l2_pos_q),
		.queue_full(q_full),
		.push(q_push),
		.entry(q_wdata)
	);

	tplv_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.rdata(q_rdata),
		.empty(q_empty)
	);

	tplv_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.entry(q_rdata),
		.empty(q_empty),
		.pop(q_pop),
		.light_one_colour(l1_col_q),
		.light_two_colour(l2_col_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue)
	);
endmodule

/* rtl/tplv_check.sv */
// Port-level checker for the vertex shader, bound to the top level.
`timescale 1ns / 1ps
module tplv_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [tplv_pkg::CHAN_W-1:0] red,
	input logic [tplv_pkg::CHAN_W-1:0] green,
	input logic [tplv_pkg::CHAN_W-1:0] blue
);
	// vertices accepted but not yet delivered
	logic [7:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
		end
	end

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 8'd0)
		else $error("result beat with no vertex outstanding");

	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 8'd0 |-> in_ready)
		else $error("input stalled while block is empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
		else $error("stalled result beat changed");
endmodule

bind two_point_light_vertex_shade tplv_check u_check (.*);
